@@ sv/gwl_pkg.sv @@
// Shared types, codes and helpers of the word-wrap line engine.
package gwl_pkg;

    localparam int LINE_DEPTH_DEF   = 64;
    localparam int COUNTER_BITS_DEF = 32;
    localparam int WIDTH_CAP        = 62;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam logic [2:0] OPC_APPEND    = 3'd0;
    localparam logic [2:0] OPC_BACKSPACE = 3'd1;
    localparam logic [2:0] OPC_DELWORD   = 3'd2;
    localparam logic [2:0] OPC_CLEAR     = 3'd3;
    localparam logic [2:0] OPC_FLUSH     = 3'd4;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_EOL    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_BACKSPACE,
        OP_DELWORD,
        OP_CLEAR,
        OP_FLUSH,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       nl;
        logic [7:0] ch;
    } cmd_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

@@ sv/gwl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/gwl_front.sv @@
// Front end: accepts edit requests, decodes them and queues them for the line engine.
module gwl_front
    import gwl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] opcode,
    input  logic [7:0] char_in,
    output cmd_t       cmd,
    output logic       cmd_valid,
    input  logic       cmd_take
);

    cmd_t       ent_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic       acc;

    always_comb
    begin
        dec.ch = char_in;
        dec.nl = (char_in == NEWLINE_BYTE);
        case (opcode)
            OPC_APPEND:    dec.op = OP_APPEND;
            OPC_BACKSPACE: dec.op = OP_BACKSPACE;
            OPC_DELWORD:   dec.op = OP_DELWORD;
            OPC_CLEAR:     dec.op = OP_CLEAR;
            OPC_FLUSH:     dec.op = OP_FLUSH;
            default:       dec.op = OP_NONE;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign acc       = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = ent_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ acc;
        rp_next  = rp_reg ^ cmd_take;
        cnt_next = cnt_reg + {1'b0, acc} - {1'b0, cmd_take};
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ent_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ sv/gwl_back.sv @@
// Back end: line state, line store walks for emit and rescan, totals and result register.
module gwl_back
    import gwl_pkg::*;
#(
    parameter int LINE_DEPTH   = LINE_DEPTH_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [5:0]  wrap_width,
    input  cmd_t        cmd,
    input  logic        cmd_valid,
    output logic        cmd_take,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  char_out,
    output logic [31:0] line_number,
    output logic [31:0] word_total,
    output logic [31:0] char_total,
    output logic        last
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int CB  = COUNTER_BITS;
    localparam int WB  = (CB > 32) ? CB : 32;
    localparam int CAP = (LINE_DEPTH - 2 < WIDTH_CAP) ? LINE_DEPTH - 2 : WIDTH_CAP;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_STATUS = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [AW-1:0]   pend_base_reg, pend_base_next;
    logic [AW-1:0]   len_reg, len_next;
    logic [5:0]      words_reg, words_next;
    logic [AW-1:0]   bp_reg, bp_next;
    logic [AW-1:0]   ws_reg, ws_next;
    logic            in_reg, in_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   lim_reg, lim_next;
    logic [5:0]      emit_w_reg, emit_w_next;
    logic [CB-1:0]   lines_reg, lines_next;
    logic [CB-1:0]   wdone_reg, wdone_next;
    logic [CB-1:0]   cdone_reg, cdone_next;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_kind_reg, out_kind_next;
    logic [7:0]      out_char_reg, out_char_next;
    logic [31:0]     out_ln_reg, out_ln_next;
    logic [31:0]     out_wt_reg, out_wt_next;
    logic [31:0]     out_ct_reg, out_ct_next;
    logic            out_last_reg, out_last_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    logic [5:0]      w6;
    logic [7:0]      ins_byte;
    logic            ins_sp;
    logic [AW-1:0]   ins_len;
    logic [5:0]      ins_words;
    logic [AW-1:0]   ins_bp;
    logic [AW-1:0]   ins_ws;
    logic            ins_in;
    logic            slot_free;
    logic [31:0]     st_ln, st_wt, st_ct;

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] b, input logic [AW-1:0] i);
        logic [AW:0] s;
        s = {1'b0, b} + {1'b0, i};
        if (s >= (AW+1)'(LINE_DEPTH))
        begin
            s = s - (AW+1)'(LINE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CB] ? {CB{1'b1}} : s[CB-1:0];
    endfunction

    function automatic logic [31:0] out32(input logic [CB-1:0] v);
        logic [WB-1:0] t;
        t = WB'(v);
        return (t > WB'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    gwl_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.ch),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clamp the width to the usable range.
    always_comb
    begin
        if (wrap_width == 6'd0)
        begin
            w6 = 6'd1;
        end
        else if (wrap_width > 6'(CAP))
        begin
            w6 = 6'(CAP);
        end
        else
        begin
            w6 = wrap_width;
        end
    end

    // Single byte insert unit, shared by append and rescan.
    always_comb
    begin
        ins_byte  = (state_reg == ST_SCAN) ? ram_rdata : cmd.ch;
        ins_sp    = is_space(ins_byte);
        ins_len   = len_reg + AW'(1);
        ins_words = words_reg;
        ins_bp    = bp_reg;
        ins_ws    = ws_reg;
        ins_in    = in_reg;
        if (ins_sp)
        begin
            if (in_reg)
            begin
                ins_bp = len_reg;
                ins_in = 1'b0;
            end
        end
        else if (!in_reg)
        begin
            ins_ws    = len_reg;
            ins_in    = 1'b1;
            ins_words = words_reg + 6'd1;
        end
    end

    assign slot_free = !out_valid_reg || pop;
    assign st_ln     = out32(sat_add(lines_reg, CB'(1)));
    assign st_wt     = out32(sat_add(wdone_reg, CB'(words_reg)));
    assign st_ct     = out32(sat_add(cdone_reg, CB'(len_reg)));
    assign ram_raddr = ring(base_reg, idx_next);
    assign ram_waddr = ring(base_reg, len_reg);

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        pend_base_next = pend_base_reg;
        len_next       = len_reg;
        words_next     = words_reg;
        bp_next        = bp_reg;
        ws_next        = ws_reg;
        in_next        = in_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        emit_w_next    = emit_w_reg;
        lines_next     = lines_reg;
        wdone_next     = wdone_reg;
        cdone_next     = cdone_reg;
        out_valid_next = out_valid_reg && !pop;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_ln_next    = out_ln_reg;
        out_wt_next    = out_wt_reg;
        out_ct_next    = out_ct_reg;
        out_last_next  = out_last_reg;
        cmd_take       = 1'b0;
        ram_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (cmd_valid)
                begin
                    cmd_take       = 1'b1;
                    state_next     = ST_STATUS;
                    pend_base_next = base_reg;
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            if (cmd.nl)
                            begin
                                lim_next    = len_reg;
                                emit_w_next = words_reg;
                                len_next    = '0;
                                words_next  = '0;
                                bp_next     = '0;
                                ws_next     = '0;
                                in_next     = 1'b0;
                                state_next  = ST_EMIT;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                len_next   = ins_len;
                                words_next = ins_words;
                                bp_next    = ins_bp;
                                ws_next    = ins_ws;
                                in_next    = ins_in;
                                if (7'(ins_len) > 7'(w6))
                                begin
                                    state_next = ST_EMIT;
                                    bp_next    = '0;
                                    ws_next    = '0;
                                    if (ins_in && (7'(ins_len - ins_ws) > 7'(w6)))
                                    begin
                                        // Hard break: new byte alone starts the next line.
                                        lim_next       = len_reg;
                                        emit_w_next    = ins_words;
                                        pend_base_next = ring(base_reg, len_reg);
                                        len_next       = AW'(1);
                                        words_next     = 6'd1;
                                        in_next        = 1'b1;
                                    end
                                    else if (ins_in)
                                    begin
                                        // Carry the partial word over.
                                        lim_next       = ins_bp;
                                        emit_w_next    = (ins_words == 6'd0) ? 6'd0
                                                                             : ins_words - 6'd1;
                                        pend_base_next = ring(base_reg, ins_ws);
                                        len_next       = ins_len - ins_ws;
                                        words_next     = 6'd1;
                                        in_next        = 1'b1;
                                    end
                                    else
                                    begin
                                        lim_next    = ins_bp;
                                        emit_w_next = ins_words;
                                        len_next    = '0;
                                        words_next  = '0;
                                        in_next     = 1'b0;
                                    end
                                end
                            end
                        end
                        OP_BACKSPACE, OP_DELWORD:
                        begin
                            if (len_reg != '0)
                            begin
                                if (cmd.op == OP_BACKSPACE)
                                begin
                                    lim_next = len_reg - AW'(1);
                                end
                                else
                                begin
                                    lim_next = (ws_reg < len_reg) ? ws_reg : len_reg;
                                end
                                len_next   = '0;
                                words_next = '0;
                                bp_next    = '0;
                                ws_next    = '0;
                                in_next    = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR, OP_FLUSH:
                        begin
                            if ((cmd.op == OP_FLUSH) && (len_reg != '0))
                            begin
                                lim_next    = len_reg;
                                emit_w_next = words_reg;
                                state_next  = ST_EMIT;
                            end
                            len_next   = '0;
                            words_next = '0;
                            bp_next    = '0;
                            ws_next    = '0;
                            in_next    = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (idx_reg == lim_reg)
                begin
                    state_next = ST_STATUS;
                end
                else
                begin
                    len_next   = ins_len;
                    words_next = ins_words;
                    bp_next    = ins_bp;
                    ws_next    = ins_ws;
                    in_next    = ins_in;
                    idx_next   = idx_reg + AW'(1);
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_ln_next    = '0;
                    out_wt_next    = '0;
                    out_ct_next    = '0;
                    out_last_next  = 1'b0;
                    if (idx_reg != lim_reg)
                    begin
                        out_kind_next = KIND_CHAR;
                        out_char_next = ram_rdata;
                        idx_next      = idx_reg + AW'(1);
                    end
                    else
                    begin
                        out_kind_next = KIND_EOL;
                        out_char_next = '0;
                        lines_next    = sat_add(lines_reg, CB'(1));
                        cdone_next    = sat_add(cdone_reg, CB'(lim_reg) + CB'(1));
                        wdone_next    = sat_add(wdone_reg, CB'(emit_w_reg));
                        base_next     = pend_base_reg;
                        state_next    = ST_STATUS;
                    end
                end
            end

            ST_STATUS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_STATUS;
                    out_char_next  = '0;
                    out_ln_next    = st_ln;
                    out_wt_next    = st_wt;
                    out_ct_next    = st_ct;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pend_base_reg <= pend_base_next;
        lim_reg       <= lim_next;
        emit_w_reg    <= emit_w_next;
        out_kind_reg  <= out_kind_next;
        out_char_reg  <= out_char_next;
        out_ln_reg    <= out_ln_next;
        out_wt_reg    <= out_wt_next;
        out_ct_reg    <= out_ct_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            len_reg       <= '0;
            words_reg     <= '0;
            bp_reg        <= '0;
            ws_reg        <= '0;
            in_reg        <= 1'b0;
            idx_reg       <= '0;
            lines_reg     <= '0;
            wdone_reg     <= '0;
            cdone_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            len_reg       <= len_next;
            words_reg     <= words_next;
            bp_reg        <= bp_next;
            ws_reg        <= ws_next;
            in_reg        <= in_next;
            idx_reg       <= idx_next;
            lines_reg     <= lines_next;
            wdone_reg     <= wdone_next;
            cdone_reg     <= cdone_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign kind        = out_kind_reg;
    assign char_out    = out_char_reg;
    assign line_number = out_ln_reg;
    assign word_total  = out_wt_reg;
    assign char_total  = out_ct_reg;
    assign last        = out_last_reg;

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (len_reg <= AW'(CAP)))
        else $error("line length above cap while idle");

    a_marks_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((ws_reg <= len_reg) && (bp_reg <= len_reg)))
        else $error("word marks beyond line end");

    a_last_only_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != KIND_STATUS)) |-> !out_last_reg)
        else $error("last set on a non-status result");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (idx_reg <= lim_reg))
        else $error("emit index past line end");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> ((state_reg == ST_IDLE) && cmd_valid))
        else $error("request taken outside idle");

endmodule

@@ sv/greedy_word_wrap_line_engine.sv @@
// Top level of the greedy word-wrap line engine.
//
// Edit requests enter through a queue-style port: push with opcode and char_in,
// taken when full is low. A two-entry request queue sits in front of the line
// engine, so requests are taken while results wait on the output.
// Results leave through a queue-style port: the oldest result is shown while
// empty is low and is taken by pop. Every request ends with one status result
// (kind 2, last high); wraps, newline and flush first give the emitted line as
// one result per character and an end-of-line result.
// A request that emits characters, or a backspace or delete-word rescan of the
// stored bytes, walks the line store through its RAM read port at one byte per
// cycle; the emit walk pauses while the result register is full.
// A stalled receiver holds the result register and stops the engine; the
// request queue then fills and full rises.
// wrap_width is written on the cfg channel (always ready); the user must write
// it only between requests, as the block itself does not enforce this.
// Reset clears the line, the totals and both queues; the width returns to 62.
module greedy_word_wrap_line_engine
    import gwl_pkg::*;
#(
    parameter int LINE_DEPTH   = LINE_DEPTH_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  opcode,
    input  logic [7:0]  char_in,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  char_out,
    output logic [31:0] line_number,
    output logic [31:0] word_total,
    output logic [31:0] char_total,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    logic [5:0] wrap_width_reg, wrap_width_next;
    cmd_t       cmd;
    logic       cmd_valid;
    logic       cmd_take;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        wrap_width_next = wrap_width_reg;
        if (cfg_valid && cfg_ready)
        begin
            wrap_width_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_width_reg <= 6'(WIDTH_CAP);
        end
        else
        begin
            wrap_width_reg <= wrap_width_next;
        end
    end

    gwl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .char_in   (char_in),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    gwl_back #(
        .LINE_DEPTH   (LINE_DEPTH),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wrap_width  (wrap_width_reg),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .char_out    (char_out),
        .line_number (line_number),
        .word_total  (word_total),
        .char_total  (char_total),
        .last        (last)
    );

endmodule
